### rtl/bilinear_image_resize_top_assert.svh
// Assertion macros for the bilinear resize block.
`ifndef BILINEAR_IMAGE_RESIZE_TOP_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_TOP_ASSERT_SVH

// Condition must never hold at a clock edge outside reset.
`define BRS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define BRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/brs_pkg.sv
// Package: constants, types and helper functions of the bilinear resize block.
`default_nettype none
package brs_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int CHANNELS   = 3;
   localparam int FRAC_BITS  = 16;
   localparam int PIXEL_BITS = 8;

   // fixed field widths
   localparam int COL_W  = 10;
   localparam int ROW_W  = 10;
   localparam int CH_W   = 2;
   localparam int PIX_W  = 8;
   localparam int SIZE_W = 11;
   localparam int STEP_W = 24;
   localparam int OFF_W  = 27;

   // position arithmetic
   localparam int POS_W = COL_W + STEP_W + 2;
   localparam int INT_W = POS_W - FRAC_BITS;
   localparam int XC_W  = $clog2(MAX_WIDTH);
   localparam int YC_W  = $clog2(MAX_HEIGHT);

   // 2x2 parity-banked frame store
   localparam int NBANKS     = 4;
   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H * CHANNELS;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);

   // blend arithmetic
   localparam int WGT_W   = FRAC_BITS + 1;
   localparam int WPROD_W = 2 * WGT_W;
   localparam int TERM_W  = WPROD_W + PIXEL_BITS;
   localparam int PAIR_W  = TERM_W + 1;
   localparam int SUM_W   = TERM_W + 2;
   localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;

   // queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int QA_W    = $clog2(Q_DEPTH);
   localparam int QC_W    = $clog2(Q_DEPTH + 1);

   // configuration register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_X        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Y        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y      = 3'd5;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_RESAMPLE = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0]       source_width;
      logic [SIZE_W-1:0]       source_height;
      logic [STEP_W-1:0]       step_x;
      logic [STEP_W-1:0]       step_y;
      logic signed [OFF_W-1:0] offset_x;
      logic signed [OFF_W-1:0] offset_y;
   } brs_cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic [CH_W-1:0]  channel;
      logic             bad_ch;
   } brs_meta_type;

   // one classified request as it crosses the queue
   typedef struct packed {
      logic                           is_load;
      logic [NBANKS-1:0]              bank_we;
      logic [PIXEL_BITS-1:0]          wdata;
      logic [NBANKS-1:0][ADDR_W-1:0]  addr;
      logic                           x1_odd;
      logic                           x2_odd;
      logic                           y1_odd;
      logic                           y2_odd;
      logic [FRAC_BITS-1:0]           fx;
      logic [FRAC_BITS-1:0]           fy;
      brs_meta_type                   meta;
   } brs_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } brs_qstat_type;

   // word address of a pixel inside its parity bank
   function automatic logic [ADDR_W-1:0] bank_addr(input logic [XC_W-1:0] x,
                                                   input logic [YC_W-1:0] y,
                                                   input logic [CH_W-1:0] ch);
      logic [ADDR_W-1:0] word_idx;
      word_idx = ADDR_W'(y >> 1) * ADDR_W'(HALF_W) + ADDR_W'(x >> 1);
      return word_idx * ADDR_W'(CHANNELS) + ADDR_W'(ch);
   endfunction

   // zero counts as one, too large counts as the maximum
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                  input int maxv);
      logic [SIZE_W-1:0] s;
      if (r == '0) begin
         s = SIZE_W'(1);
      end else if (int'(r) > maxv) begin
         s = SIZE_W'(maxv);
      end else begin
         s = r;
      end
      return s;
   endfunction

   // clamp a signed coordinate to 0 .. size-1
   function automatic logic [SIZE_W-1:0] clamp_coord(input logic signed [INT_W:0] v,
                                                     input logic [SIZE_W-1:0] size);
      logic signed [INT_W:0] top_v;
      logic [SIZE_W-1:0]     c;
      top_v = $signed((INT_W+1)'(size)) - (INT_W+1)'(1);
      if (v < 0) begin
         c = '0;
      end else if (v > top_v) begin
         c = size - SIZE_W'(1);
      end else begin
         c = SIZE_W'(v);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/brs_req_if.sv
// Interface: request channel of the bilinear resize block.
`default_nettype none
interface brs_req_if import brs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [COL_W-1:0] column;
   logic [ROW_W-1:0] row;
   logic [CH_W-1:0]  channel;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output operation, output column, output row,
                   output channel, output pixel_in, input ready);
   modport sink (input valid, input operation, input column, input row,
                 input channel, input pixel_in, output ready);
endinterface
`default_nettype wire

### rtl/brs_rsp_if.sv
// Interface: result channel of the bilinear resize block.
`default_nettype none
interface brs_rsp_if import brs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic [COL_W-1:0] out_column;
   logic [ROW_W-1:0] out_row;
   logic [CH_W-1:0]  out_channel;

   modport source (output valid, output pixel_out, output out_column, output out_row,
                   output out_channel, input ready);
   modport sink (input valid, input pixel_out, input out_column, input out_row,
                 input out_channel, output ready);
endinterface
`default_nettype wire

### rtl/brs_front.sv
// Front end: accepts requests, maps positions, clamps neighbors, builds bank addresses.
`default_nettype none
module brs_front import brs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   brs_req_if.sink            req_bus,
   input  wire brs_cfg_type   cfg,
   input  wire brs_qstat_type qstat,
   output logic               push,
   output brs_entry_type      entry
);

   logic adv;

   logic                    s1_valid_ff;
   logic                    s1_op_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [CH_W-1:0]         s1_ch_ff;
   logic [PIX_W-1:0]        s1_pix_ff;
   logic signed [POS_W-1:0] s1_px_ff;
   logic signed [POS_W-1:0] s1_py_ff;
   logic signed [POS_W-1:0] px_in;
   logic signed [POS_W-1:0] py_in;

   logic          e_valid_ff;
   brs_entry_type entry_ff;
   brs_entry_type entry_in;

   // front stalls only when its output entry cannot enter the queue
   assign adv           = !(e_valid_ff && qstat.full);
   assign req_bus.ready = adv;
   assign push          = e_valid_ff && !qstat.full;
   assign entry         = entry_ff;

   // source position: index * step + offset
   always_comb begin
      px_in = $signed(POS_W'(req_bus.column) * POS_W'(cfg.step_x))
            + $signed({{(POS_W-OFF_W){cfg.offset_x[OFF_W-1]}}, cfg.offset_x});
      py_in = $signed(POS_W'(req_bus.row) * POS_W'(cfg.step_y))
            + $signed({{(POS_W-OFF_W){cfg.offset_y[OFF_W-1]}}, cfg.offset_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (adv) begin
         s1_op_ff  <= req_bus.operation;
         s1_col_ff <= req_bus.column;
         s1_row_ff <= req_bus.row;
         s1_ch_ff  <= req_bus.channel;
         s1_pix_ff <= req_bus.pixel_in;
         s1_px_ff  <= px_in;
         s1_py_ff  <= py_in;
      end
   end

   // floor, fraction, clamping and per-bank address selection
   always_comb begin
      logic signed [INT_W:0] bx0;
      logic signed [INT_W:0] bx1;
      logic signed [INT_W:0] by0;
      logic signed [INT_W:0] by1;
      logic [SIZE_W-1:0]     sw;
      logic [SIZE_W-1:0]     sh;
      logic [XC_W-1:0]       x1;
      logic [XC_W-1:0]       x2;
      logic [YC_W-1:0]       y1;
      logic [YC_W-1:0]       y2;
      logic [XC_W-1:0]       xs;
      logic [YC_W-1:0]       ys;
      logic [CH_W-1:0]       chs;
      logic                  bad;
      logic                  in_range;
      logic [1:0]            lb;

      sw  = eff_size(cfg.source_width, MAX_WIDTH);
      sh  = eff_size(cfg.source_height, MAX_HEIGHT);
      bx0 = $signed({s1_px_ff[POS_W-1], s1_px_ff[POS_W-1:FRAC_BITS]});
      by0 = $signed({s1_py_ff[POS_W-1], s1_py_ff[POS_W-1:FRAC_BITS]});
      bx1 = bx0 + (INT_W+1)'(1);
      by1 = by0 + (INT_W+1)'(1);
      x1  = XC_W'(clamp_coord(bx0, sw));
      x2  = XC_W'(clamp_coord(bx1, sw));
      y1  = YC_W'(clamp_coord(by0, sh));
      y2  = YC_W'(clamp_coord(by1, sh));
      xs  = x1;
      ys  = y1;

      bad      = (int'(s1_ch_ff) >= CHANNELS);
      chs      = bad ? '0 : s1_ch_ff;
      in_range = (int'(s1_col_ff) < MAX_WIDTH) && (int'(s1_row_ff) < MAX_HEIGHT) && !bad;
      lb       = {s1_row_ff[0], s1_col_ff[0]};

      entry_in             = '0;
      entry_in.is_load     = (s1_op_ff == OP_LOAD);
      entry_in.wdata       = PIXEL_BITS'(s1_pix_ff);
      entry_in.x1_odd      = x1[0];
      entry_in.x2_odd      = x2[0];
      entry_in.y1_odd      = y1[0];
      entry_in.y2_odd      = y2[0];
      entry_in.fx          = s1_px_ff[FRAC_BITS-1:0];
      entry_in.fy          = s1_py_ff[FRAC_BITS-1:0];
      entry_in.meta.column = s1_col_ff;
      entry_in.meta.row    = s1_row_ff;
      entry_in.meta.channel = s1_ch_ff;
      entry_in.meta.bad_ch = bad;

      for (int b = 0; b < NBANKS; b++) begin
         if (s1_op_ff == OP_LOAD) begin
            entry_in.addr[b]    = bank_addr(XC_W'(s1_col_ff), YC_W'(s1_row_ff), chs);
            entry_in.bank_we[b] = in_range && (lb == 2'(b));
         end else begin
            // each bank reads the neighbor whose parity matches it
            xs = (x1[0] == b[0]) ? x1 : x2;
            ys = (y1[0] == b[1]) ? y1 : y2;
            entry_in.addr[b] = bank_addr(xs, ys, chs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         entry_ff <= entry_in;
      end
   end

endmodule
`default_nettype wire

### rtl/brs_queue.sv
// Short show-ahead queue between front end and back end.
`default_nettype none
module brs_queue import brs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire brs_entry_type push_entry,
   input  wire logic          pop,
   output brs_entry_type      head,
   output brs_qstat_type      qstat
);

   brs_entry_type   slot_ff [Q_DEPTH];
   logic [QA_W-1:0] wr_ptr_ff;
   logic [QA_W-1:0] rd_ptr_ff;
   logic [QC_W-1:0] count_ff;

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QC_W'(Q_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QA_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QA_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### rtl/brs_back.sv
// Back end: banked frame store, weight products, blend and rounding, result register.
`default_nettype none
module brs_back import brs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire brs_qstat_type qstat,
   input  wire brs_entry_type head,
   output logic               pop,
   brs_rsp_if.source          rsp_bus
);

   logic adv;
   logic [NBANKS-1:0][PIXEL_BITS-1:0] rdata;

   // stage 1: store read, weight products
   logic                              v1_ff;
   brs_meta_type                      m1_ff;
   logic [1:0]                        i11_ff;
   logic [1:0]                        i21_ff;
   logic [1:0]                        i12_ff;
   logic [1:0]                        i22_ff;
   logic [NBANKS-1:0][WPROD_W-1:0]    w_ff;
   logic [NBANKS-1:0][WPROD_W-1:0]    w_in;

   // stage 2: weighted terms
   logic                              v2_ff;
   brs_meta_type                      m2_ff;
   logic [NBANKS-1:0][TERM_W-1:0]     t_ff;
   logic [NBANKS-1:0][TERM_W-1:0]     t_in;

   // stage 3: pair sums
   logic                              v3_ff;
   brs_meta_type                      m3_ff;
   logic [PAIR_W-1:0]                 s01_ff;
   logic [PAIR_W-1:0]                 s23_ff;

   // stage 4: result register
   logic                              out_valid_ff;
   logic [PIX_W-1:0]                  pix_ff;
   brs_meta_type                      m4_ff;
   logic [PIX_W-1:0]                  pix_in;

   assign adv = !(out_valid_ff && !rsp_bus.ready);
   assign pop = adv && !qstat.empty;

   // four parity banks, one write and one read each per cycle
   for (genvar b = 0; b < NBANKS; b++) begin : g_bank
      logic [PIXEL_BITS-1:0] mem [BANK_DEPTH];
      logic [PIXEL_BITS-1:0] rdata_ff;
      always_ff @(posedge clock) begin
         if (pop && head.is_load && head.bank_we[b]) begin
            mem[head.addr[b]] <= head.wdata;
         end
         if (adv) begin
            rdata_ff <= mem[head.addr[b]];
         end
      end
      assign rdata[b] = rdata_ff;
   end

   always_comb begin
      logic [WGT_W-1:0] fx;
      logic [WGT_W-1:0] fy;
      logic [WGT_W-1:0] gx;
      logic [WGT_W-1:0] gy;
      fx = WGT_W'(head.fx);
      fy = WGT_W'(head.fy);
      gx = WGT_W'(1 << FRAC_BITS) - fx;
      gy = WGT_W'(1 << FRAC_BITS) - fy;
      w_in[0] = WPROD_W'(gx) * WPROD_W'(gy);
      w_in[1] = WPROD_W'(fx) * WPROD_W'(gy);
      w_in[2] = WPROD_W'(gx) * WPROD_W'(fy);
      w_in[3] = WPROD_W'(fx) * WPROD_W'(fy);
   end

   always_comb begin
      t_in[0] = TERM_W'(rdata[i11_ff]) * TERM_W'(w_ff[0]);
      t_in[1] = TERM_W'(rdata[i21_ff]) * TERM_W'(w_ff[1]);
      t_in[2] = TERM_W'(rdata[i12_ff]) * TERM_W'(w_ff[2]);
      t_in[3] = TERM_W'(rdata[i22_ff]) * TERM_W'(w_ff[3]);
   end

   // final sum, round half up, saturate; a bad channel gives zero
   always_comb begin
      logic [SUM_W-1:0] acc;
      logic [SUM_W-1:0] res;
      acc = SUM_W'(s01_ff) + SUM_W'(s23_ff) + (SUM_W'(1) << (2 * FRAC_BITS - 1));
      res = acc >> (2 * FRAC_BITS);
      if (res > SUM_W'(PIX_MAX)) begin
         res = SUM_W'(PIX_MAX);
      end
      pix_in = m3_ff.bad_ch ? '0 : PIX_W'(res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= pop && !head.is_load;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
      if (adv) begin
         m1_ff  <= head.meta;
         i11_ff <= {head.y1_odd, head.x1_odd};
         i21_ff <= {head.y1_odd, head.x2_odd};
         i12_ff <= {head.y2_odd, head.x1_odd};
         i22_ff <= {head.y2_odd, head.x2_odd};
         w_ff   <= w_in;
         m2_ff  <= m1_ff;
         t_ff   <= t_in;
         m3_ff  <= m2_ff;
         s01_ff <= PAIR_W'(t_ff[0]) + PAIR_W'(t_ff[1]);
         s23_ff <= PAIR_W'(t_ff[2]) + PAIR_W'(t_ff[3]);
         m4_ff  <= m3_ff;
         pix_ff <= pix_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pixel_out   = pix_ff;
   assign rsp_bus.out_column  = m4_ff.column;
   assign rsp_bus.out_row     = m4_ff.row;
   assign rsp_bus.out_channel = m4_ff.channel;

endmodule
`default_nettype wire

### rtl/bilinear_image_resize_top.sv
// Top level of the bilinear image resize block: configuration registers and datapath.
//
// Usage:
//   req_bus carries requests. A load request (operation 0) writes one source
//   pixel into the internal frame store and yields no result. A resample
//   request (operation 1) names a destination column, row and channel and
//   yields exactly one result on rsp_bus, in request order.
//   csr_* is an APB-style port holding source size, step and offset registers;
//   write it only while the block is idle.
//   Throughput: one request per cycle unless rsp_bus stalls, loads and resamples
//   mixed freely; the four neighbors come from a 2x2 parity-banked store in one read.
//   Path to result valid: the input stage loads at the accepting edge, then
//   the entry stage, the queue and the four back-end stages follow.
//   Reset clears all valid state and sets the registers to their defaults;
//   the frame store content is undefined until loaded.
//   When rsp_bus stalls, the back end holds, the 4-entry queue fills, and then
//   req_bus.ready drops; nothing is lost or repeated.
`default_nettype none
`include "bilinear_image_resize_top_assert.svh"
module bilinear_image_resize_top import brs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   brs_req_if.sink                    req_bus,
   brs_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   brs_cfg_type   cfg_ff;
   logic          csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   logic          q_push;
   logic          q_pop;
   brs_entry_type q_in;
   brs_entry_type q_head;
   brs_qstat_type q_stat;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= SIZE_W'(1024);
         cfg_ff.source_height <= SIZE_W'(1024);
         cfg_ff.step_x        <= STEP_W'(65536);
         cfg_ff.step_y        <= STEP_W'(65536);
         cfg_ff.offset_x      <= '0;
         cfg_ff.offset_y      <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_SOURCE_WIDTH:  cfg_ff.source_width  <= csr_pwdata[SIZE_W-1:0];
            REG_SOURCE_HEIGHT: cfg_ff.source_height <= csr_pwdata[SIZE_W-1:0];
            REG_STEP_X:        cfg_ff.step_x        <= csr_pwdata[STEP_W-1:0];
            REG_STEP_Y:        cfg_ff.step_y        <= csr_pwdata[STEP_W-1:0];
            REG_OFFSET_X:      cfg_ff.offset_x      <= $signed(csr_pwdata[OFF_W-1:0]);
            REG_OFFSET_Y:      cfg_ff.offset_y      <= $signed(csr_pwdata[OFF_W-1:0]);
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         REG_SOURCE_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.source_width);
         REG_SOURCE_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.source_height);
         REG_STEP_X:        csr_prdata = CSR_DATA_W'(cfg_ff.step_x);
         REG_STEP_Y:        csr_prdata = CSR_DATA_W'(cfg_ff.step_y);
         REG_OFFSET_X:      csr_prdata = CSR_DATA_W'(cfg_ff.offset_x);
         REG_OFFSET_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.offset_y);
         default:           csr_prdata = '0;
      endcase
   end

   brs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg_ff),
      .qstat   (q_stat),
      .push    (q_push),
      .entry   (q_in)
   );

   brs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .qstat      (q_stat)
   );

   brs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (q_stat),
      .head    (q_head),
      .pop     (q_pop),
      .rsp_bus (rsp_bus)
   );

   // checks
   `BRS_ASSERT_NEVER(a_no_overflow, clock, reset, q_push && q_stat.full, "queue overflow")
   `BRS_ASSERT_NEVER(a_no_underflow, clock, reset, q_pop && q_stat.empty, "queue underflow")
   `BRS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_bus.valid, "result after reset")

endmodule
`default_nettype wire
